@@ rtl/octs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package octs_pkg;

	// Window geometry
	localparam int HEADER_LEN = 21;
	localparam int TYPE_LEN   = 19;
	localparam int HIST_DEPTH = HEADER_LEN - 1;
	localparam int FILL_W     = 5;
	localparam int HIST_W     = HIST_DEPTH * 8;

	// Signatures, first character in the most significant byte
	localparam logic [HEADER_LEN*8-1:0] HEADER_SIG = {"[Con", "tent_Types]", ".xmlPK"};
	localparam logic [TYPE_LEN*8-1:0]   SIG_WORD   = "document.xml.relsPK";
	localparam logic [TYPE_LEN*8-1:0]   SIG_SHEET  = "workbook.xml.relsPK";
	localparam logic [TYPE_LEN*8-1:0]   SIG_SLIDES = "entation.xml.relsPK";

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_TYPE   = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		VERDICT_WORD           = 3'd0,
		VERDICT_SHEET          = 3'd1,
		VERDICT_SLIDES         = 3'd2,
		VERDICT_HEADER_MISSING = 3'd3,
		VERDICT_TYPE_MISSING   = 3'd4
	} verdict_t;

	typedef struct packed {
		logic     has_result;
		verdict_t verdict;
		phase_t   phase_next;
	} match_t;

endpackage
`default_nettype wire

@@ rtl/octs_match.sv @@
`timescale 1ns / 1ps
`default_nettype none
module octs_match (
	input  wire logic [octs_pkg::HIST_W-1:0] hist,
	input  wire logic [7:0]                  cur,
	input  wire logic [octs_pkg::FILL_W-1:0] fill,
	input  wire octs_pkg::phase_t            phase,
	input  wire logic                        last,
	output octs_pkg::match_t                 match
);

	logic [octs_pkg::HEADER_LEN*8-1:0] win;
	logic hdr_hit;
	logic type_ok;
	logic hit_word;
	logic hit_sheet;
	logic hit_slides;
	logic any_hit;

	// Build the window, oldest byte on top, and compare against the signatures
	assign win        = {hist, cur};
	assign hdr_hit    = (fill >= octs_pkg::FILL_W'(octs_pkg::HIST_DEPTH))
		&& (win == octs_pkg::HEADER_SIG);
	assign type_ok    = fill >= octs_pkg::FILL_W'(octs_pkg::TYPE_LEN - 1);
	assign hit_word   = win[octs_pkg::TYPE_LEN*8-1:0] == octs_pkg::SIG_WORD;
	assign hit_sheet  = win[octs_pkg::TYPE_LEN*8-1:0] == octs_pkg::SIG_SHEET;
	assign hit_slides = win[octs_pkg::TYPE_LEN*8-1:0] == octs_pkg::SIG_SLIDES;
	assign any_hit    = type_ok && (hit_word || hit_sheet || hit_slides);

	// Next phase
	always_comb begin
		case (phase)
			octs_pkg::PH_HEADER: match.phase_next = hdr_hit ? octs_pkg::PH_TYPE
				: octs_pkg::PH_HEADER;
			octs_pkg::PH_TYPE:   match.phase_next = any_hit ? octs_pkg::PH_DONE
				: octs_pkg::PH_TYPE;
			default:             match.phase_next = octs_pkg::PH_DONE;
		endcase
	end

	// Result for this byte; the earliest matching type wins
	always_comb begin
		match.has_result = 1'b0;
		match.verdict    = octs_pkg::VERDICT_HEADER_MISSING;
		case (phase)
			octs_pkg::PH_HEADER: begin
				match.has_result = last;
				match.verdict    = hdr_hit ? octs_pkg::VERDICT_TYPE_MISSING
					: octs_pkg::VERDICT_HEADER_MISSING;
			end
			octs_pkg::PH_TYPE: begin
				match.has_result = any_hit || last;
				if (!any_hit)
					match.verdict = octs_pkg::VERDICT_TYPE_MISSING;
				else if (hit_word)
					match.verdict = octs_pkg::VERDICT_WORD;
				else if (hit_sheet)
					match.verdict = octs_pkg::VERDICT_SHEET;
				else
					match.verdict = octs_pkg::VERDICT_SLIDES;
			end
			default: begin
				match.has_result = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/office_container_type_sniffer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Scans a file one byte per item for the package header signature and then for
// a word, spreadsheet or presentation part name, and gives one verdict per file:
// the first type found, or header missing / type missing at the byte marked last.
// An item is taken every cycle unless input is stalled. The deciding byte of a verdict
// passes the input register, then the parallel 21-byte window compare into the result
// register, and a held verdict stalls input only when a further verdict is due.
module office_container_type_sniffer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_valid,
	output logic            data_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            verdict_valid,
	input  wire logic       verdict_stall,
	output logic [2:0]      verdict
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        last_s1;
	logic [octs_pkg::HIST_W-1:0] hist_q;
	logic [octs_pkg::FILL_W-1:0] fill_q;
	octs_pkg::phase_t            phase_q;
	octs_pkg::verdict_t          verdict_q;
	logic                        out_valid_q;
	octs_pkg::match_t            match;
	logic                        slot_free;
	logic                        go_s1;

	octs_match u_match (
		.hist  (hist_q),
		.cur   (byte_s1),
		.fill  (fill_q),
		.phase (phase_q),
		.last  (last_s1),
		.match (match)
	);

	// Advance the stage unless its verdict finds the result register held by a stalled verdict
	assign slot_free  = !out_valid_q || !verdict_stall;
	assign go_s1      = valid_s1 && (!match.has_result || slot_free);
	assign data_stall = valid_s1 && !go_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Shift the window and step the phase; drop everything after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			fill_q  <= '0;
			phase_q <= octs_pkg::PH_HEADER;
		end else if (go_s1) begin
			if (last_s1) begin
				hist_q  <= '0;
				fill_q  <= '0;
				phase_q <= octs_pkg::PH_HEADER;
			end else begin
				hist_q  <= {hist_q[octs_pkg::HIST_W-9:0], byte_s1};
				if (fill_q < octs_pkg::FILL_W'(octs_pkg::HIST_DEPTH))
					fill_q <= fill_q + octs_pkg::FILL_W'(1);
				phase_q <= match.phase_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= go_s1 && match.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && go_s1 && match.has_result)
			verdict_q <= match.verdict;
	end

	assign verdict_valid = out_valid_q;
	assign verdict       = verdict_q;

endmodule
`default_nettype wire

@@ rtl/octs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module octs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       data_valid,
	input wire logic       data_stall,
	input wire logic [7:0] data_byte,
	input wire logic       last_byte,
	input wire logic       verdict_valid,
	input wire logic       verdict_stall,
	input wire logic [2:0] verdict
);

	// A stalled verdict holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
		else $error("verdict changed while stalled");

	// A stalled input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && data_stall |=> data_valid && $stable(data_byte) && $stable(last_byte))
		else $error("input item changed while stalled");

	// Only defined verdict codes leave the block
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> verdict <= octs_pkg::VERDICT_TYPE_MISSING)
		else $error("undefined verdict code");

	// With the result register empty, input is never held off
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!verdict_valid |-> !data_stall)
		else $error("input stalled with no verdict pending");

	// A fresh verdict follows an item taken in through the input register
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(verdict_valid) |-> $past(data_valid && !data_stall, 2))
		else $error("verdict without a causing item");

endmodule

bind office_container_type_sniffer_core octs_checker u_octs_checker (.*);
`default_nettype wire

@@ dv/tb_office_container_type_sniffer_core.sv @@
`timescale 1ns / 1ps
module tb_office_container_type_sniffer_core;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_WAIT  = 16;
	localparam int RAND_BYTES  = 1200;

	// One byte of a file as it travels to the block
	typedef struct {
		logic [7:0]         data;
		logic               last;
		bit                 has_lit;
		octs_pkg::verdict_t lit;
	} sniff_item_t;

	// One directed file: a run of a filler byte, then text. In the text '#' stands
	// for the whole header signature, '<' for its first 15 bytes and '>' for all
	// but its first byte.
	typedef struct {
		logic [7:0]         lead;
		int                 lead_n;
		string              text;
		bit                 has_lit;
		octs_pkg::verdict_t lit;
	} file_row_t;

	file_row_t dir_rows [15] = '{
		'{8'h00, 1, "", 1'b1, octs_pkg::VERDICT_HEADER_MISSING},
		'{8'hFF, 1, "", 1'b1, octs_pkg::VERDICT_HEADER_MISSING},
		'{8'h00, 0, "#", 1'b1, octs_pkg::VERDICT_TYPE_MISSING},
		'{8'h00, 0, "#document.xml.relsPK", 1'b1, octs_pkg::VERDICT_WORD},
		'{8'h00, 0, "#zzworkbook.xml.relsPKtail", 1'b1, octs_pkg::VERDICT_SHEET},
		'{8'h00, 0, "#presentation.xml.relsPK!", 1'b1, octs_pkg::VERDICT_SLIDES},
		'{8'h00, 0, "#_no_part_name_", 1'b1, octs_pkg::VERDICT_TYPE_MISSING},
		'{8'h00, 0, ">", 1'b1, octs_pkg::VERDICT_HEADER_MISSING},
		'{8'hFF, 3, "<", 1'b1, octs_pkg::VERDICT_HEADER_MISSING},
		'{8'h00, 0, ".xmlPKdocument.xml.relsPK", 1'b1, octs_pkg::VERDICT_HEADER_MISSING},
		'{8'h00, 0, "document.xml.relsPK#", 1'b1, octs_pkg::VERDICT_TYPE_MISSING},
		'{8'h00, 20, "#", 1'b1, octs_pkg::VERDICT_TYPE_MISSING},
		'{8'h00, 0, "#document.xml.relsPKworkbook.xml.relsPK", 1'b0, octs_pkg::VERDICT_WORD},
		'{8'h00, 0, "xx#entation.xml.relsPK", 1'b0, octs_pkg::VERDICT_WORD},
		'{8'h00, 0, "##", 1'b0, octs_pkg::VERDICT_WORD}
	};

	octs_pkg::verdict_t part_kinds [3] = '{octs_pkg::VERDICT_WORD, octs_pkg::VERDICT_SHEET,
		octs_pkg::VERDICT_SLIDES};

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       data_valid    = 1'b0;
	logic       data_stall;
	logic [7:0] data_byte     = 8'h00;
	logic       last_byte     = 1'b0;
	logic       verdict_valid;
	logic       verdict_stall = 1'b0;
	logic [2:0] verdict;

	// Predictor state
	logic [octs_pkg::HIST_W-1:0] sniff_hist  = '0;
	int unsigned                 sniff_fill  = 0;
	octs_pkg::phase_t            sniff_phase = octs_pkg::PH_HEADER;

	sniff_item_t        byte_q [$];
	logic [7:0]         file_bytes [$];
	octs_pkg::verdict_t verdict_due_q [$];

	bit                 drv_has_lit = 1'b0;
	octs_pkg::verdict_t drv_lit     = octs_pkg::VERDICT_WORD;
	bit          steady      = 1'b0;
	int unsigned send_gap    = 0;
	int unsigned stall_left  = 0;
	int unsigned long_hold_asked = 0;
	int unsigned long_hold_done  = 0;

	int unsigned queued_count   = 0;
	int unsigned accepted_count = 0;
	int unsigned file_count     = 0;
	int unsigned in_stalls      = 0;
	int unsigned err_count      = 0;
	int unsigned cycle_count    = 0;
	int unsigned verdict_seen [5] = '{0, 0, 0, 0, 0};

	office_container_type_sniffer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.verdict_valid(verdict_valid),
		.verdict_stall(verdict_stall),
		.verdict      (verdict)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (err_count < 40)
			$display("mismatch @%0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// Work out the verdict, if any, that one byte causes, and advance the window
	task automatic sniff_verdict(input logic [7:0] b, input logic is_last,
			output bit has, output octs_pkg::verdict_t v);
		logic [octs_pkg::HEADER_LEN*8-1:0] win;
		logic [octs_pkg::TYPE_LEN*8-1:0]   part;
		bit                                hit;
		win  = {sniff_hist, b};
		part = win[octs_pkg::TYPE_LEN*8-1:0];
		has  = 1'b0;
		hit  = 1'b0;
		v    = octs_pkg::VERDICT_HEADER_MISSING;
		case (sniff_phase)
			octs_pkg::PH_HEADER: begin
				if (sniff_fill >= octs_pkg::HIST_DEPTH && win == octs_pkg::HEADER_SIG) begin
					sniff_phase = octs_pkg::PH_TYPE;
					// header on the final byte leaves no room for a part name
					if (is_last) begin
						has = 1'b1;
						v   = octs_pkg::VERDICT_TYPE_MISSING;
					end
				end else if (is_last) begin
					has = 1'b1;
					v   = octs_pkg::VERDICT_HEADER_MISSING;
				end
			end
			octs_pkg::PH_TYPE: begin
				// first match wins: word, then sheet, then slides
				if (sniff_fill >= octs_pkg::TYPE_LEN - 1) begin
					if (part == octs_pkg::SIG_WORD) begin
						hit = 1'b1;
						v   = octs_pkg::VERDICT_WORD;
					end else if (part == octs_pkg::SIG_SHEET) begin
						hit = 1'b1;
						v   = octs_pkg::VERDICT_SHEET;
					end else if (part == octs_pkg::SIG_SLIDES) begin
						hit = 1'b1;
						v   = octs_pkg::VERDICT_SLIDES;
					end
				end
				if (hit) begin
					has         = 1'b1;
					sniff_phase = octs_pkg::PH_DONE;
				end else if (is_last) begin
					has = 1'b1;
					v   = octs_pkg::VERDICT_TYPE_MISSING;
				end
			end
			default: ;
		endcase
		// clear at end of file, else shift the byte in
		if (is_last) begin
			sniff_hist  = '0;
			sniff_fill  = 0;
			sniff_phase = octs_pkg::PH_HEADER;
		end else begin
			sniff_hist = {sniff_hist[octs_pkg::HIST_W-9:0], b};
			if (sniff_fill < octs_pkg::HIST_DEPTH)
				sniff_fill++;
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] header_byte(input int k);
		return octs_pkg::HEADER_SIG[(octs_pkg::HEADER_LEN-1-k)*8 +: 8];
	endfunction

	function automatic logic [7:0] part_byte(input octs_pkg::verdict_t t, input int k);
		logic [octs_pkg::TYPE_LEN*8-1:0] sig;
		case (t)
			octs_pkg::VERDICT_WORD:  sig = octs_pkg::SIG_WORD;
			octs_pkg::VERDICT_SHEET: sig = octs_pkg::SIG_SHEET;
			default:                 sig = octs_pkg::SIG_SLIDES;
		endcase
		return sig[(octs_pkg::TYPE_LEN-1-k)*8 +: 8];
	endfunction

	// Mostly random bytes, some taken from the signatures to make near misses
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 5))
			0:       return header_byte($urandom_range(0, octs_pkg::HEADER_LEN-1));
			1:       return part_byte(part_kinds[$urandom_range(0, 2)],
					$urandom_range(0, octs_pkg::TYPE_LEN-1));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Append header bytes lo to hi to the file being built
	task automatic push_header(input int lo, input int hi);
		for (int k = lo; k <= hi; k++)
			file_bytes.push_back(header_byte(k));
	endtask

	// Move the built file into the send queue, marking its final byte
	task automatic send_file(input bit has_lit, input octs_pkg::verdict_t lit);
		sniff_item_t it;
		while (file_bytes.size() != 0) begin
			it.data    = file_bytes.pop_front();
			it.last    = (file_bytes.size() == 0);
			it.has_lit = has_lit;
			it.lit     = lit;
			byte_q.push_back(it);
			queued_count++;
		end
		file_count++;
	endtask

	task automatic build_random_file();
		int unsigned        kind;
		int                 flip_at;
		octs_pkg::verdict_t t;
		logic [7:0]         b;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			// container with random content around the signatures, now and then with a flipped bit or no part name
			repeat ($urandom_range(0, 6)) file_bytes.push_back(noise_byte());
			flip_at = ($urandom_range(0, 7) == 0)
				? $urandom_range(0, octs_pkg::HEADER_LEN-1) : -1;
			for (int k = 0; k < octs_pkg::HEADER_LEN; k++) begin
				b = header_byte(k);
				if (k == flip_at)
					b ^= 8'(1 << $urandom_range(0, 7));
				file_bytes.push_back(b);
			end
			repeat ($urandom_range(0, 8)) file_bytes.push_back(noise_byte());
			if ($urandom_range(0, 9) != 0) begin
				t       = part_kinds[$urandom_range(0, 2)];
				flip_at = ($urandom_range(0, 7) == 0)
					? $urandom_range(0, octs_pkg::TYPE_LEN-1) : -1;
				for (int k = 0; k < octs_pkg::TYPE_LEN; k++) begin
					b = part_byte(t, k);
					if (k == flip_at)
						b ^= 8'(1 << $urandom_range(0, 7));
					file_bytes.push_back(b);
				end
			end
			repeat ($urandom_range(0, 5)) file_bytes.push_back(noise_byte());
		end else if (kind < 85) begin
			// header cut short at the end of the file
			repeat ($urandom_range(0, 3)) file_bytes.push_back(noise_byte());
			for (int k = 0; k < $urandom_range(1, octs_pkg::HEADER_LEN-1); k++)
				file_bytes.push_back(header_byte(k));
		end else begin
			repeat ($urandom_range(1, 30)) file_bytes.push_back(noise_byte());
		end
		if (file_bytes.size() == 0)
			file_bytes.push_back(noise_byte());
		send_file(1'b0, octs_pkg::VERDICT_WORD);
	endtask

	// Hold the sender until every queued byte is taken and every verdict is back
	task automatic wait_all_verdicts();
		while (accepted_count != queued_count || verdict_due_q.size() != 0)
			@(posedge clk);
	endtask

	// Offer bytes with random gaps; hold the payload while stalled
	always @(posedge clk) begin : drive_bytes
		sniff_item_t nxt;
		if (arst_n && (!data_valid || !data_stall)) begin
			if (send_gap > 0) begin
				data_valid <= 1'b0;
				send_gap   <= send_gap - 1;
			end else if (byte_q.size() != 0) begin
				nxt = byte_q.pop_front();
				data_valid  <= 1'b1;
				data_byte   <= nxt.data;
				last_byte   <= nxt.last;
				drv_has_lit <= nxt.has_lit;
				drv_lit     <= nxt.lit;
				send_gap    <= pick_gap();
			end else begin
				data_valid <= 1'b0;
			end
		end
	end

	// Stall the verdict side at random, with one long hold on request
	always @(posedge clk) begin : drive_stall
		int unsigned n;
		if (arst_n) begin
			if (long_hold_done != long_hold_asked) begin
				long_hold_done <= long_hold_asked;
				stall_left     <= LONG_HOLD;
				verdict_stall  <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left    <= stall_left - 1;
				verdict_stall <= 1'b1;
			end else begin
				n = pick_gap();
				stall_left    <= (n > 0) ? n - 1 : 0;
				verdict_stall <= (n > 0);
			end
		end
	end

	// Predict on every accepted byte
	always @(posedge clk) begin : take_bytes
		bit                 has;
		octs_pkg::verdict_t v;
		if (arst_n && data_valid) begin
			if (data_stall) begin
				in_stalls++;
			end else begin
				sniff_verdict(data_byte, last_byte, has, v);
				if (has)
					verdict_due_q.push_back(drv_has_lit ? drv_lit : v);
				accepted_count++;
			end
		end
	end

	// Compare each accepted verdict with the oldest one due
	always @(posedge clk) begin : check_verdicts
		octs_pkg::verdict_t want;
		if (arst_n && verdict_valid && !verdict_stall) begin
			if (verdict_due_q.size() == 0) begin
				report_mismatch($sformatf("verdict %0d with none due", verdict));
			end else begin
				want = verdict_due_q.pop_front();
				if (verdict !== want)
					report_mismatch($sformatf("verdict %0d, want %0d", verdict, want));
				else
					verdict_seen[want]++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned rand_start;
		int unsigned rand_files;
		logic [7:0]  ch;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed files
		foreach (dir_rows[r]) begin
			repeat (dir_rows[r].lead_n) file_bytes.push_back(dir_rows[r].lead);
			for (int i = 0; i < dir_rows[r].text.len(); i++) begin
				ch = dir_rows[r].text[i];
				case (ch)
					"#":     push_header(0, octs_pkg::HEADER_LEN-1);
					"<":     push_header(0, 14);
					">":     push_header(1, octs_pkg::HEADER_LEN-1);
					default: file_bytes.push_back(ch);
				endcase
			end
			send_file(dir_rows[r].has_lit, dir_rows[r].lit);
		end
		wait_all_verdicts();

		// long output hold while short files keep coming, to fill the block
		steady = 1'b1;
		long_hold_asked++;
		repeat (40) begin
			repeat ($urandom_range(1, 3)) file_bytes.push_back(noise_byte());
			send_file(1'b0, octs_pkg::VERDICT_WORD);
		end
		wait_all_verdicts();
		steady = 1'b0;

		// random files, with a full pause now and then
		rand_start = queued_count;
		rand_files = 0;
		while (queued_count - rand_start < RAND_BYTES || rand_files < 20) begin
			steady = ($urandom_range(0, 7) == 0);
			build_random_file();
			rand_files++;
			if ($urandom_range(0, 19) == 0)
				wait_all_verdicts();
			while (byte_q.size() > 64)
				@(posedge clk);
		end
		steady = 1'b0;
		wait_all_verdicts();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d files, %0d bytes, %0d input stall cycles",
			file_count, accepted_count, in_stalls);
		$display("verdicts: word %0d sheet %0d slides %0d no header %0d no type %0d",
			verdict_seen[octs_pkg::VERDICT_WORD], verdict_seen[octs_pkg::VERDICT_SHEET],
			verdict_seen[octs_pkg::VERDICT_SLIDES],
			verdict_seen[octs_pkg::VERDICT_HEADER_MISSING],
			verdict_seen[octs_pkg::VERDICT_TYPE_MISSING]);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ office_container_type_sniffer_core.f @@
rtl/octs_pkg.sv
rtl/octs_match.sv
rtl/office_container_type_sniffer_core.sv
rtl/octs_checker.sv
dv/tb_office_container_type_sniffer_core.sv
